### design/bdtw_pkg.sv
`default_nettype none
package bdtw_pkg;
  localparam int Window     = 128;
  localparam int IdxBits    = $clog2(Window);
  localparam int SampleBits = 24;
  localparam int CostBits   = 32;
  localparam int SigBits    = 31;
  localparam int SumBits    = 31;
  localparam int BandBits   = 8;
  localparam int DevBits    = SampleBits + 1;
  localparam int ColBits    = $clog2(Window + 1);

  localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};
  localparam logic [SigBits-1:0]  SigMax  = {SigBits{1'b1}};

  localparam logic ActRef  = 1'b0;
  localparam logic ActPush = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_REF_RD, ST_REF_WR, ST_PUSH_RD, ST_PUSH_WR,
    ST_INIT, ST_SIG, ST_ROW, ST_CELL, ST_DONE
  } state_t;
endpackage
`default_nettype wire

### design/bdtw_ram.sv
`default_nettype none
module bdtw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/bdtw_cell.sv
`default_nettype none
// One DTW cell: local distance plus min of three neighbors, saturating.
module bdtw_cell (
  input  wire logic signed [bdtw_pkg::DevBits-1:0]  ref_dev,
  input  wire logic signed [bdtw_pkg::DevBits-1:0]  tst_dev,
  input  wire logic        [bdtw_pkg::CostBits-1:0] diag,
  input  wire logic        [bdtw_pkg::CostBits-1:0] left,
  input  wire logic        [bdtw_pkg::CostBits-1:0] up,
  output logic             [bdtw_pkg::CostBits-1:0] cost
);
  import bdtw_pkg::*;
  logic signed [DevBits:0]   d;
  logic        [DevBits:0]   ad;
  logic        [CostBits-1:0] m;
  logic        [CostBits:0]   s;

  always_comb begin
    d = {ref_dev[DevBits-1], ref_dev} - {tst_dev[DevBits-1], tst_dev};
    ad = d[DevBits] ? -d : d;
    m = (diag < left) ? diag : left;
    if (up < m) begin
      m = up;
    end
    s = {1'b0, m} + {{(CostBits - DevBits){1'b0}}, ad};
    cost = s[CostBits] ? CostMax : s[CostBits-1:0];
  end
endmodule
`default_nettype wire

### design/banded_dtw_sliding_matcher_core.sv
`default_nettype none
// Banded DTW matcher.
// Input channel (in_valid/in_ready): in_action 0 writes reference entry
// in_ref_index with in_sample_value; 1 pushes a test sample into the
// 128-deep sliding window. Reference writes give no result; pushes give
// one result (out_warp_distance, out_signature_length) once the window
// holds 128 samples.
// Config channel (cfg_valid/cfg_ready) writes band_width; write only when
// idle.
// A reference write passes through a read state and a write state. A push
// that yields a result computes one cost cell per cycle over
// the full 128x128 grid, limited by the single read port of the cost-row
// memory and the sample ring. One item is worked at a time.
// Reset: the reference store is cleared by a pass over all 128 entries
// after reset; in_ready stays low meanwhile. Window and sums start empty.
// Stall: the result sits in an output register; the next item is still
// accepted while it waits, but its own result waits for the slot to free.
module banded_dtw_sliding_matcher_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic [6:0]                        in_ref_index,
  input  wire logic [bdtw_pkg::SampleBits-1:0]   in_sample_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bdtw_pkg::CostBits-1:0]     out_warp_distance,
  output logic      [bdtw_pkg::SigBits-1:0]      out_signature_length,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bdtw_pkg::BandBits-1:0]     cfg_band_width
);
  import bdtw_pkg::*;

  state_t state_r, state_nxt;
  logic [BandBits-1:0]   band_r;
  logic [IdxBits-1:0]    idx_r;
  logic [SampleBits-1:0] val_r;
  logic [IdxBits-1:0]    ptr_r;
  logic [IdxBits:0]      fill_r;
  logic [SumBits-1:0]    rsum_r, ssum_r;
  logic [IdxBits:0]      cnt_r;       // clear/init/sig counter
  logic [ColBits-1:0]    i_r, j_r;
  logic [CostBits-1:0]   left_r, diag_r;
  logic [SigBits+1:0]    sig_r;
  logic                  ov_r;
  logic [CostBits-1:0]   ow_r;
  logic [SigBits-1:0]    os_r;

  // reference ram
  logic                  rf_we;
  logic [IdxBits-1:0]    rf_wa, rf_ra;
  logic [SampleBits-1:0] rf_wd, rf_rd;
  // sample ring
  logic                  sr_we;
  logic [IdxBits-1:0]    sr_wa, sr_ra;
  logic [SampleBits-1:0] sr_rd;
  // previous cost row (cols 1..Window stored at j-1)
  logic                  cr_we;
  logic [IdxBits-1:0]    cr_wa, cr_ra;
  logic [CostBits-1:0]   cr_wd, cr_rd;

  bdtw_ram #(.Width(SampleBits), .Depth(Window)) u_ref (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_rd));
  bdtw_ram #(.Width(SampleBits), .Depth(Window)) u_ring (
    .clk, .we(sr_we), .waddr(sr_wa), .wdata(val_r), .raddr(sr_ra), .rdata(sr_rd));
  bdtw_ram #(.Width(CostBits), .Depth(Window)) u_row (
    .clk, .we(cr_we), .waddr(cr_wa), .wdata(cr_wd), .raddr(cr_ra), .rdata(cr_rd));

  logic [SampleBits-1:0] rmean, smean;
  assign rmean = SampleBits'(rsum_r >> IdxBits);
  assign smean = SampleBits'(ssum_r >> IdxBits);

  logic signed [DevBits-1:0] rdev, tdev;
  assign rdev = DevBits'($signed({1'b0, rf_rd}) - $signed({1'b0, rmean}));
  assign tdev = DevBits'($signed({1'b0, sr_rd}) - $signed({1'b0, smean}));

  // Band test for cell (i,j): |i-j| <= band
  logic [ColBits:0] dij;
  logic             in_band;
  assign dij = (i_r >= j_r) ? {1'b0, i_r - j_r} : {1'b0, j_r - i_r};
  assign in_band = dij <= {{(ColBits + 1 - BandBits){1'b0}}, band_r};

  logic [CostBits-1:0] up, cell_cost, cost_out;
  assign up = cr_rd;
  bdtw_cell u_cell (.ref_dev(rdev), .tst_dev(tdev), .diag(diag_r), .left(left_r),
    .up(up), .cost(cell_cost));
  assign cost_out = in_band ? cell_cost : CostMax;

  logic last_cnt;
  assign last_cnt = cnt_r == (IdxBits + 1)'(Window - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (last_cnt) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid && in_ready)
                    state_nxt = (in_action == ActRef) ? ST_REF_RD : ST_PUSH_RD;
      ST_REF_RD:  state_nxt = ST_REF_WR;
      ST_REF_WR:  state_nxt = ST_IDLE;
      ST_PUSH_RD: state_nxt = ST_PUSH_WR;
      ST_PUSH_WR: state_nxt = (fill_r >= (IdxBits + 1)'(Window - 1)) ? ST_INIT : ST_IDLE;
      ST_INIT:    if (last_cnt) state_nxt = ST_SIG;
      ST_SIG:     if (cnt_r == (IdxBits + 1)'(Window)) state_nxt = ST_ROW;
      ST_ROW:     state_nxt = ST_CELL;
      ST_CELL:    if (j_r == ColBits'(Window))
                    state_nxt = (i_r == ColBits'(Window)) ? ST_DONE : ST_ROW;
      ST_DONE:    if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == ST_IDLE;
    cfg_ready = 1'b1;
    rf_we = 1'b0; rf_wa = idx_r; rf_wd = val_r; rf_ra = idx_r;
    sr_we = 1'b0; sr_wa = ptr_r; sr_ra = ptr_r;
    cr_we = 1'b0; cr_wa = cnt_r[IdxBits-1:0]; cr_wd = CostMax; cr_ra = '0;
    case (state_r)
      ST_CLEAR: begin
        rf_we = 1'b1; rf_wa = cnt_r[IdxBits-1:0]; rf_wd = '0;
      end
      ST_REF_WR: rf_we = 1'b1;
      ST_PUSH_WR: sr_we = 1'b1;
      ST_INIT: begin
        cr_we = 1'b1;
        rf_ra = '0;
      end
      ST_SIG: rf_ra = IdxBits'(cnt_r + 1'b1);
      ST_ROW: begin
        rf_ra = IdxBits'(i_r - 1'b1);
        sr_ra = ptr_r;
        cr_ra = '0;
      end
      ST_CELL: begin
        rf_ra = IdxBits'(i_r - 1'b1);
        sr_ra = ptr_r + IdxBits'(j_r);
        cr_ra = IdxBits'(j_r);
        cr_we = 1'b1; cr_wa = IdxBits'(j_r - 1'b1); cr_wd = cost_out;
      end
      default: ;
    endcase
  end

  logic [SampleBits:0] adev;
  assign adev = rdev[DevBits-1] ? -rdev : rdev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      band_r <= BandBits'(Window);
      ptr_r <= '0; fill_r <= '0; rsum_r <= '0; ssum_r <= '0;
      cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) band_r <= cfg_band_width;
      // load the result slot once it is free; left_r holds the last cell
      if (state_r == ST_DONE && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
        ow_r <= left_r;
        os_r <= (sig_r > (SigBits + 2)'(SigMax)) ? SigMax : sig_r[SigBits-1:0];
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        ST_IDLE: if (in_valid && in_ready) begin
          idx_r <= in_ref_index; val_r <= in_sample_value;
          cnt_r <= '0;
        end
        ST_REF_WR: rsum_r <= rsum_r - SumBits'(rf_rd) + SumBits'(val_r);
        ST_PUSH_WR: begin
          ssum_r <= ssum_r - (fill_r[IdxBits] ? SumBits'(sr_rd) : '0) + SumBits'(val_r);
          ptr_r <= ptr_r + 1'b1;
          if (!fill_r[IdxBits]) fill_r <= fill_r + 1'b1;
          sig_r <= '0;
        end
        ST_INIT: cnt_r <= last_cnt ? '0 : cnt_r + 1'b1;
        ST_SIG: begin
          if (cnt_r != '0) sig_r <= sig_r + (SigBits + 2)'(adev);
          cnt_r <= cnt_r + 1'b1;
          i_r <= ColBits'(1);
        end
        ST_ROW: begin
          j_r <= ColBits'(1);
          left_r <= CostMax;
          diag_r <= (i_r == ColBits'(1)) ? '0 : CostMax;
        end
        ST_CELL: begin
          left_r <= cost_out;
          diag_r <= up;
          j_r <= j_r + 1'b1;
          if (j_r == ColBits'(Window)) i_r <= i_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ST_PUSH_RD reads old ring slot at ptr; ST_REF_RD reads old ref entry.
  assign out_valid = ov_r;
  assign out_warp_distance = ow_r;
  assign out_signature_length = os_r;
endmodule
`default_nettype wire

### design/bdtw_checker.sv
`default_nettype none
module bdtw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_warp_distance
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_warp_distance))
    else $error("result dropped while stalled");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
endmodule
bind banded_dtw_sliding_matcher_core bdtw_checker u_chk (.*);
`default_nettype wire

### verif/bdtw_checker.sv
`timescale 1ns / 1ps
module bdtw_scoreboard (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          in_action,
  input  wire logic [6:0]                    in_ref_index,
  input  wire logic [bdtw_pkg::SampleBits-1:0] in_sample_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [bdtw_pkg::CostBits-1:0] out_warp_distance,
  input  wire logic [bdtw_pkg::SigBits-1:0]  out_signature_length,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [bdtw_pkg::BandBits-1:0] cfg_band_width,
  output int                                 fail_count,
  output int                                 pending
);
  import bdtw_pkg::*;

  typedef struct packed {
    logic [CostBits-1:0] warp;
    logic [SigBits-1:0]  sig;
  } match_t;

  match_t              match_q[$];
  logic [BandBits-1:0] band;
  logic [SampleBits-1:0] ref_mem[Window];
  logic [SampleBits-1:0] ring_mem[Window];
  int                  wr_ptr;
  int                  fill;
  longint              ref_total;
  longint              win_total;
  longint              ref_dev[Window];
  longint              win_dev[Window];
  longint              prev_row[Window+1];
  longint              cur_row[Window+1];

  localparam longint CostSat = 64'h0000_0000_FFFF_FFFF;

  function automatic longint banded_warp_cost();
    longint lo, hi, d, m, w;
    w = band;
    prev_row[0] = 0;
    for (int j = 1; j <= Window; j++) prev_row[j] = CostSat;
    for (int i = 1; i <= Window; i++) begin
      lo = (i - w < 1) ? 1 : i - w;
      hi = (i + w > Window) ? Window : i + w;
      cur_row[0] = CostSat;
      for (int j = 1; j <= Window; j++) begin
        if (j < lo || j > hi) begin
          cur_row[j] = CostSat;
        end else begin
          d = ref_dev[i-1] - win_dev[j-1];
          if (d < 0) d = -d;
          if (d > CostSat) d = CostSat;
          m = prev_row[j-1];
          if (cur_row[j-1] < m) m = cur_row[j-1];
          if (prev_row[j] < m) m = prev_row[j];
          d = d + m;
          cur_row[j] = (d > CostSat) ? CostSat : d;
        end
      end
      prev_row = cur_row;
    end
    return prev_row[Window];
  endfunction

  task automatic push_sample(input logic [SampleBits-1:0] v);
    longint rmean, smean, sig, d;
    match_t m;
    if (fill >= Window) win_total -= ring_mem[wr_ptr];
    ring_mem[wr_ptr] = v;
    win_total += v;
    wr_ptr = (wr_ptr + 1) % Window;
    if (fill < Window) fill++;
    if (fill < Window) return;
    rmean = ref_total / Window;
    smean = win_total / Window;
    sig = 0;
    for (int k = 0; k < Window; k++) begin
      d = longint'(ref_mem[k]) - rmean;
      ref_dev[k] = d;
      sig += (d < 0) ? -d : d;
      win_dev[k] = longint'(ring_mem[(wr_ptr + k) % Window]) - smean;
    end
    m.warp = CostBits'(banded_warp_cost());
    m.sig = (sig > SigMax) ? SigMax : sig[SigBits-1:0];
    match_q.push_back(m);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      band <= 8'd128;
      for (int k = 0; k < Window; k++) ref_mem[k] = '0;
      wr_ptr = 0;
      fill = 0;
      ref_total = 0;
      win_total = 0;
      match_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result warp=%0d sig=%0d", $time,
                   out_warp_distance, out_signature_length);
          fail_count <= fail_count + 1;
        end else begin
          match_t e;
          e = match_q.pop_front();
          if (e.warp !== out_warp_distance || e.sig !== out_signature_length) begin
            $display("%0t: mismatch expected warp=%0d sig=%0d actual warp=%0d sig=%0d",
                     $time, e.warp, e.sig, out_warp_distance, out_signature_length);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) band <= cfg_band_width;
      if (in_valid && in_ready) begin
        if (in_action == ActRef) begin
          ref_total -= ref_mem[in_ref_index];
          ref_mem[in_ref_index] = in_sample_value;
          ref_total += in_sample_value;
        end else begin
          push_sample(in_sample_value);
        end
      end
    end
    pending <= match_q.size();
  end
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import bdtw_pkg::*;

  localparam int CycleLimit = 4_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [6:0]            in_ref_index;
  logic [SampleBits-1:0] in_sample_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CostBits-1:0]   out_warp_distance;
  logic [SigBits-1:0]    out_signature_length;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [BandBits-1:0]   cfg_band_width;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    cycles = 0;

  banded_dtw_sliding_matcher_core u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_ref_index, .in_sample_value,
    .out_valid, .out_ready, .out_warp_distance, .out_signature_length,
    .cfg_valid, .cfg_ready, .cfg_band_width
  );

  bdtw_scoreboard u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_ref_index, .in_sample_value,
    .out_valid, .out_ready, .out_warp_distance, .out_signature_length,
    .cfg_valid, .cfg_ready, .cfg_band_width, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("banded_dtw_sliding_matcher_core verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [SampleBits-1:0] pick_value();
    case ($urandom_range(5))
      0:       return '0;
      1:       return {SampleBits{1'b1}};
      2:       return SampleBits'($urandom_range(255));
      default: return SampleBits'($urandom());
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [6:0] idx,
                           input logic [SampleBits-1:0] v);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_action = act;
    in_ref_index = idx;
    in_sample_value = v;
    forever begin
      #1;
      if (in_ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // hold until the block has drained, then let it settle before a register write
  task automatic wait_idle();
    while (pending != 0 || out_valid) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_band(input logic [BandBits-1:0] bw);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_band_width = bw;
    forever begin
      #1;
      if (cfg_ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int n);
    logic [BandBits-1:0] bands[10] = '{0, 1, 2, 5, 64, 126, 127, 128, 200, 255};
    logic [BandBits-1:0] bw;
    bw = ($urandom_range(3) == 0) ? BandBits'($urandom()) : bands[$urandom_range(9)];
    write_band(bw);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 7) send_beat(ActPush, 7'($urandom()), pick_value());
      else send_beat(ActRef, 7'($urandom()), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ActRef;
    in_ref_index = '0;
    in_sample_value = '0;
    cfg_valid = 1'b0;
    cfg_band_width = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    write_band(8'd128);
    send_beat(ActRef, 7'd0, {SampleBits{1'b1}});
    send_beat(ActRef, 7'd127, '0);
    send_beat(ActRef, 7'd64, 24'h800000);
    send_beat(ActRef, 7'd64, 24'h555555);
    send_beat(ActRef, 7'h2A, 24'hAAAAAA);
    for (int k = 0; k < 32; k++) send_beat(ActRef, 7'($urandom()), pick_value());
    // fill the window: these pushes give nothing until the last one
    send_beat(ActPush, 7'h7F, '0);
    send_beat(ActPush, 7'h00, {SampleBits{1'b1}});
    for (int k = 2; k < Window; k++) send_beat(ActPush, 7'($urandom()), pick_value());
    send_beat(ActPush, 7'd5, 24'h000001);
    write_band(8'd0);
    send_beat(ActPush, 7'd0, {SampleBits{1'b1}});
    write_band(8'd1);
    send_beat(ActPush, 7'd0, '0);
    write_band(8'd127);
    send_beat(ActPush, 7'd0, 24'h123456);
    write_band(8'd255);
    send_beat(ActPush, 7'd0, 24'h800000);

    random_phase(0, 0, 12);
    random_phase(79, 0, 12);
    random_phase(0, 79, 12);
    random_phase(38, 38, 12);
    random_phase(0, 0, 6);

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("banded_dtw_sliding_matcher_core verification clean");
    else
      $display("banded_dtw_sliding_matcher_core verification failed");
    $finish;
  end
endmodule
